>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FJSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FJSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/fjsp_pkg.sv
// Types and constants of the flat JSON string pair parser.
`default_nettype none

package fjsp_pkg;

    localparam int RES_MAX = 6;   // most results one input word can cause
    localparam int Q_DEPTH = 8;   // result queue entries
    localparam int Q_AW    = 3;   // result queue address width
    localparam int Q_CW    = 4;   // result queue fill count width

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_KEY_END = 3'd1,
        EV_VAL_END = 3'd2,
        EV_DONE    = 3'd3,
        EV_ERROR   = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        PH_START,
        PH_BOM,
        PH_PRE,
        PH_OPEN,
        PH_STR,
        PH_COLON,
        PH_VALQ,
        PH_SEP,
        PH_COMMA,
        PH_IDLE
    } t_phase;

    typedef enum logic [2:0] {
        ESC_NONE,
        ESC_BS,
        ESC_HEX1,
        ESC_PEND,
        ESC_PEND_BS,
        ESC_HEX2
    } t_esc;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_end;
    } t_in;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] out_byte;
        logic       field_is_value;
        logic       last;
    } t_out;

    // All results of one input word, entry 0 first.
    typedef struct packed {
        logic [2:0]              cnt;
        t_out [RES_MAX-1:0]      ent;
    } t_res_list;

endpackage

`default_nettype wire

>>> rtl/flat_json_string_pair_parser_top.sv
// Top level of the flat JSON string pair parser.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out)
//
// One input word is taken per cycle unless o_in_stall is high; its step runs in the
// same cycle and its results (0 to 6) land in an 8-entry queue, which issues one
// word a cycle unless i_out_stall is high. Input stalls only while more than 2
// results wait, so words with at most one result stream at full rate; an escape
// expanding to more than one byte can stall the input, depending on queue fill.
// Reset is synchronous, active low, and empties the queue at once.
`default_nettype none

module flat_json_string_pair_parser_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire fjsp_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output fjsp_pkg::t_out       o_out_data
);

    logic                 in_acc;
    logic                 out_pop;
    logic                 q_full;
    fjsp_pkg::t_res_list  list;

    assign o_in_stall = q_full;
    assign in_acc     = i_in_valid && !q_full;
    assign out_pop    = o_out_valid && !i_out_stall;

    fjsp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_item   (i_in_data),
        .o_list   (list)
    );

    fjsp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_list  (list),
        .i_pop   (out_pop),
        .o_valid (o_out_valid),
        .o_full  (q_full),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/fjsp_parser.sv
// Parser state and the one-word step that builds the result list.
`default_nettype none

module fjsp_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire fjsp_pkg::t_in      i_item,
    output fjsp_pkg::t_res_list     o_list
);

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } t_utf8;

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp < 21'h80) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len  = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len  = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // bit 4 set: valid hex digit, value in bits 3:0
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    fjsp_pkg::t_phase r_phase, n_phase;
    fjsp_pkg::t_esc   r_esc, n_esc;
    logic [1:0]       r_bom, n_bom;
    logic             r_inval, n_inval;
    logic [1:0]       r_hex, n_hex;
    logic [15:0]      r_acc, n_acc;
    logic [9:0]       r_pend, n_pend;
    logic             r_fin, n_fin;
    logic             r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fjsp_pkg::PH_START;
            r_esc   <= fjsp_pkg::ESC_NONE;
            r_bom   <= '0;
            r_inval <= 1'b0;
            r_hex   <= '0;
            r_acc   <= '0;
            r_pend  <= '0;
            r_fin   <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_bom   <= n_bom;
            r_inval <= n_inval;
            r_hex   <= n_hex;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_fin   <= n_fin;
            r_err   <= n_err;
        end
    end

    // Results of a step: optional lone-high prefix, then at most one main part.
    logic                 pf;
    logic                 mk_byte, mk_ev, mk_cp;
    logic [7:0]           m_byte;
    fjsp_pkg::t_event     m_ev;
    logic                 m_fv;
    logic [20:0]          m_cp;
    logic                 do_plain, do_escape;
    logic [7:0]           c;
    logic [4:0]           hv;
    logic [15:0]          acc_n;
    logic [7:0]           esc_v;

    always_comb begin
        n_phase   = r_phase;
        n_esc     = r_esc;
        n_bom     = r_bom;
        n_inval   = r_inval;
        n_hex     = r_hex;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_fin     = r_fin;
        n_err     = r_err;
        pf        = 1'b0;
        mk_byte   = 1'b0;
        mk_ev     = 1'b0;
        mk_cp     = 1'b0;
        m_byte    = '0;
        m_ev      = fjsp_pkg::EV_ERROR;
        m_fv      = 1'b0;
        m_cp      = '0;
        do_plain  = 1'b0;
        do_escape = 1'b0;
        esc_v     = '0;
        c         = i_item.data_byte;
        hv        = hex_val(c);
        acc_n     = {r_acc[11:0], hv[3:0]};

        if (i_item.text_end) begin
            if (!r_fin && !r_err) begin
                mk_ev = 1'b1;
                m_ev  = fjsp_pkg::EV_ERROR;
            end
            n_phase = fjsp_pkg::PH_START;
            n_esc   = fjsp_pkg::ESC_NONE;
            n_bom   = '0;
            n_inval = 1'b0;
            n_hex   = '0;
            n_acc   = '0;
            n_pend  = '0;
            n_fin   = 1'b0;
            n_err   = 1'b0;
        end else begin
            case (r_phase)
                fjsp_pkg::PH_START: begin
                    if (c == 8'hEF) begin
                        n_bom   = 2'd1;
                        n_phase = fjsp_pkg::PH_BOM;
                    end else if (is_ws(c)) begin
                        n_phase = fjsp_pkg::PH_PRE;
                    end else if (c == "{") begin
                        n_phase = fjsp_pkg::PH_OPEN;
                    end else begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_BOM: begin
                    if (r_bom == 2'd1 && c == 8'hBB) begin
                        n_bom = 2'd2;
                    end else if (r_bom == 2'd2 && c == 8'hBF) begin
                        n_bom   = 2'd3;
                        n_phase = fjsp_pkg::PH_PRE;
                    end else begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_PRE: begin
                    if (c == "{") begin
                        n_phase = fjsp_pkg::PH_OPEN;
                    end else if (!is_ws(c)) begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_OPEN: begin
                    if (c == "}") begin
                        n_fin   = 1'b1;
                        n_phase = fjsp_pkg::PH_IDLE;
                        mk_ev   = 1'b1;
                        m_ev    = fjsp_pkg::EV_DONE;
                    end else if (c == "\"") begin
                        n_inval = 1'b0;
                        n_esc   = fjsp_pkg::ESC_NONE;
                        n_phase = fjsp_pkg::PH_STR;
                    end else if (!is_ws(c)) begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_COLON: begin
                    if (c == ":") begin
                        n_phase = fjsp_pkg::PH_VALQ;
                    end else if (!is_ws(c)) begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_VALQ: begin
                    if (c == "\"") begin
                        n_inval = 1'b1;
                        n_esc   = fjsp_pkg::ESC_NONE;
                        n_phase = fjsp_pkg::PH_STR;
                    end else if (!is_ws(c)) begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_SEP: begin
                    if (c == ",") begin
                        n_phase = fjsp_pkg::PH_COMMA;
                    end else if (c == "}") begin
                        n_fin   = 1'b1;
                        n_phase = fjsp_pkg::PH_IDLE;
                        mk_ev   = 1'b1;
                        m_ev    = fjsp_pkg::EV_DONE;
                    end else if (!is_ws(c)) begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_COMMA: begin
                    if (c == "\"") begin
                        n_inval = 1'b0;
                        n_esc   = fjsp_pkg::ESC_NONE;
                        n_phase = fjsp_pkg::PH_STR;
                    end else if (!is_ws(c)) begin
                        mk_ev = 1'b1;
                    end
                end
                fjsp_pkg::PH_STR: begin
                    case (r_esc)
                        fjsp_pkg::ESC_NONE: begin
                            do_plain = 1'b1;
                        end
                        fjsp_pkg::ESC_BS: begin
                            do_escape = 1'b1;
                        end
                        fjsp_pkg::ESC_HEX1, fjsp_pkg::ESC_HEX2: begin
                            if (!hv[4]) begin
                                mk_ev = 1'b1;
                            end else begin
                                n_acc = acc_n;
                                n_hex = r_hex + 2'd1;
                                if (r_hex == 2'd3) begin
                                    if (r_esc == fjsp_pkg::ESC_HEX2
                                        && acc_n[15:10] == 6'b110111) begin
                                        // surrogate pair
                                        mk_cp  = 1'b1;
                                        m_cp   = 21'(21'h10000 + {r_pend, acc_n[9:0]});
                                        n_pend = '0;
                                        n_esc  = fjsp_pkg::ESC_NONE;
                                    end else begin
                                        pf = (r_esc == fjsp_pkg::ESC_HEX2);
                                        if (acc_n[15:10] == 6'b110110) begin
                                            n_pend = acc_n[9:0];
                                            n_esc  = fjsp_pkg::ESC_PEND;
                                        end else begin
                                            n_pend = '0;
                                            mk_cp  = 1'b1;
                                            m_cp   = {5'd0, acc_n};
                                            n_esc  = fjsp_pkg::ESC_NONE;
                                        end
                                    end
                                end
                            end
                        end
                        fjsp_pkg::ESC_PEND: begin
                            if (c == "\\") begin
                                n_esc = fjsp_pkg::ESC_PEND_BS;
                            end else begin
                                pf       = 1'b1;
                                n_pend   = '0;
                                n_esc    = fjsp_pkg::ESC_NONE;
                                do_plain = 1'b1;
                            end
                        end
                        fjsp_pkg::ESC_PEND_BS: begin
                            if (c == "u") begin
                                n_esc = fjsp_pkg::ESC_HEX2;
                                n_hex = '0;
                                n_acc = '0;
                            end else begin
                                pf        = 1'b1;
                                n_pend    = '0;
                                do_escape = 1'b1;
                            end
                        end
                        default: begin
                            mk_ev = 1'b1;
                        end
                    endcase

                    if (do_plain) begin
                        if (c == "\"") begin
                            n_esc = fjsp_pkg::ESC_NONE;
                            mk_ev = 1'b1;
                            m_fv  = r_inval;
                            if (r_inval) begin
                                m_ev    = fjsp_pkg::EV_VAL_END;
                                n_phase = fjsp_pkg::PH_SEP;
                            end else begin
                                m_ev    = fjsp_pkg::EV_KEY_END;
                                n_phase = fjsp_pkg::PH_COLON;
                            end
                        end else if (c == "\\") begin
                            n_esc = fjsp_pkg::ESC_BS;
                        end else begin
                            mk_byte = 1'b1;
                            m_byte  = c;
                        end
                    end

                    if (do_escape) begin
                        n_esc   = fjsp_pkg::ESC_NONE;
                        mk_byte = 1'b1;
                        case (c)
                            "\"", "\\", "/": esc_v = c;
                            "n":             esc_v = 8'h0A;
                            "t":             esc_v = 8'h09;
                            "r":             esc_v = 8'h0D;
                            "b":             esc_v = 8'h08;
                            "f":             esc_v = 8'h0C;
                            "u": begin
                                mk_byte = 1'b0;
                                n_esc   = fjsp_pkg::ESC_HEX1;
                                n_hex   = '0;
                                n_acc   = '0;
                            end
                            default: begin
                                mk_byte = 1'b0;
                                mk_ev   = 1'b1;
                            end
                        endcase
                        m_byte = esc_v;
                    end
                end
                default: begin
                end
            endcase

            // syntax error: every error path of a step lands here, but for the one at text end
            if (mk_ev && m_ev == fjsp_pkg::EV_ERROR) begin
                n_err   = 1'b1;
                n_phase = fjsp_pkg::PH_IDLE;
                n_esc   = fjsp_pkg::ESC_NONE;
            end
        end
    end

    // Assemble the result list.
    t_utf8      pre_enc, main_enc;
    logic [2:0] off, mlen, cnt, j;

    always_comb begin
        pre_enc  = utf8_enc({5'd0, 6'b110110, r_pend});
        main_enc = utf8_enc(m_cp);
        off      = pf ? 3'd3 : 3'd0;
        mlen     = mk_cp ? main_enc.len : ((mk_byte || mk_ev) ? 3'd1 : 3'd0);
        cnt      = off + mlen;
        o_list.cnt = cnt;
        for (int k = 0; k < fjsp_pkg::RES_MAX; k++) begin
            j = 3'(k) - off;
            o_list.ent[k] = '0;
            if (pf && k < 3) begin
                o_list.ent[k].event_res      = fjsp_pkg::EV_DATA;
                o_list.ent[k].out_byte       = pre_enc.b[k];
                o_list.ent[k].field_is_value = r_inval;
            end else if (mk_cp) begin
                o_list.ent[k].event_res      = fjsp_pkg::EV_DATA;
                o_list.ent[k].out_byte       = main_enc.b[j[1:0]];
                o_list.ent[k].field_is_value = r_inval;
            end else if (mk_byte) begin
                o_list.ent[k].event_res      = fjsp_pkg::EV_DATA;
                o_list.ent[k].out_byte       = m_byte;
                o_list.ent[k].field_is_value = r_inval;
            end else begin
                o_list.ent[k].event_res      = m_ev;
                o_list.ent[k].field_is_value = m_fv;
            end
            o_list.ent[k].last = (3'(k) == cnt - 3'd1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/fjsp_resq.sv
// Result queue: takes a list of up to six words at once, hands out one a cycle while not stalled.
`default_nettype none

module fjsp_resq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire fjsp_pkg::t_res_list i_list,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output logic                     o_full,
    output fjsp_pkg::t_out           o_data
);

    fjsp_pkg::t_out                  r_mem [fjsp_pkg::Q_DEPTH];
    logic [fjsp_pkg::Q_AW-1:0]       r_wr, r_rd, n_wr, n_rd;
    logic [fjsp_pkg::Q_CW-1:0]       r_cnt, n_cnt;
    logic [2:0]                      push_n;

    assign push_n  = i_push ? i_list.cnt : 3'd0;
    assign n_wr    = r_wr + fjsp_pkg::Q_AW'(push_n);
    assign n_rd    = r_rd + fjsp_pkg::Q_AW'(i_pop);
    assign n_cnt   = r_cnt + fjsp_pkg::Q_CW'(push_n) - fjsp_pkg::Q_CW'(i_pop);
    assign o_valid = (r_cnt != '0);
    // room must remain for a full list from the next word
    assign o_full  = (r_cnt > fjsp_pkg::Q_CW'(fjsp_pkg::Q_DEPTH - fjsp_pkg::RES_MAX));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < fjsp_pkg::RES_MAX; k++) begin
            if (3'(k) < push_n) begin
                r_mem[r_wr + fjsp_pkg::Q_AW'(k)] <= i_list.ent[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/fjsp_checker.sv
// Port-level checks of the parser top, bound onto it.
`default_nettype none
`include "assert_macros.svh"

module fjsp_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            o_in_stall,
    input  wire fjsp_pkg::t_in   i_in_data,
    input  wire logic            o_out_valid,
    input  wire logic            i_out_stall,
    input  wire fjsp_pkg::t_out  o_out_data
);

    logic in_seen;
    assign in_seen = i_in_valid || i_in_data.text_end;

    // nothing pending and ready right after reset
    `FJSP_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), (!o_out_valid && !o_in_stall) || (in_seen && !o_out_valid && !o_in_stall))

    // completion and error are always the final word of their step
    `FJSP_ASSERT_NOW(a_final_last, i_clk, i_rst_n, o_out_valid && (o_out_data.event_res == fjsp_pkg::EV_DONE || o_out_data.event_res == fjsp_pkg::EV_ERROR), o_out_data.last)

    // only data words carry a byte
    `FJSP_ASSERT_NOW(a_nondata_zero, i_clk, i_rst_n, o_out_valid && o_out_data.event_res != fjsp_pkg::EV_DATA, o_out_data.out_byte == 8'h00)

    // a stalled output word holds
    `FJSP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind flat_json_string_pair_parser_top fjsp_checker u_fjsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
